/* rtl/umpq_pkg.sv */
// shared constants, op and error codes, controller/datapath interface structs
`timescale 1ns / 1ps
`default_nettype none

package umpq_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int KEY_W = 32;
	localparam int OP_W  = 3;
	localparam int ERR_W = 2;
	localparam int OCC_W = 7;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK     = 3'd2;
	localparam logic [OP_W-1:0] OP_DELETE   = 3'd3;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd4;
	localparam logic [OP_W-1:0] OP_SIZE     = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd6;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic decide;
		logic issue;
		logic commit;
		logic move_rd;
		logic move_wr;
		logic out_load;
	} umpq_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            empty;
		logic            scan_last;
	} umpq_sts_t;

endpackage

`default_nettype wire

/* rtl/unordered_min_priority_queue_top.sv */
// top level of the unordered min-priority queue
//
// min-priority queue over signed 32-bit keys, kept unsorted in a key store of
// CAPACITY entries with one read and one write port, plus an occupancy count.
// one request beat carries op and key, and each request yields exactly one
// result beat.
// requests are taken one at a time: in_ready is high only while the block
// is idle, but a finished result waits in the output register so the next
// request can be taken before the result is drained. insert, size, clear,
// the unused op code, errored requests and scans of an empty store skip
// the scan and go straight to the result. remove-min, peek-min, delete-all and
// contains scan every stored key through the one store read port, one entry
// per cycle; remove-min then moves the last entry into the vacated slot.
// delete-all compacts the store during the same pass. the store needs no
// clearing after reset, only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module unordered_min_priority_queue_top
	import umpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// request channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [OP_W-1:0]         op,
	input  wire logic signed [KEY_W-1:0] key,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [KEY_W-1:0]      min_key,
	output logic                         hit,
	output logic [ERR_W-1:0]             error_code,
	output logic [OCC_W-1:0]             occupancy
);

	umpq_cmd_t cmd;
	umpq_sts_t sts;

	// sequencer: decides the path of each request and drives the handshakes
	umpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// key store, count, scan compare and result registers
	umpq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (op),
		.in_key     (key),
		.min_key    (min_key),
		.hit        (hit),
		.error_code (error_code),
		.occupancy  (occupancy)
	);

	// only one request in flight: an accepted beat drops in_ready next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// a full refusal reports the store at capacity
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
		else $error("full error with store not at capacity");

	// an empty error reports a zero key, no hit and an empty store
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_EMPTY) |-> (min_key == '0 && !hit && occupancy == '0))
		else $error("empty error with inconsistent result");

	// a hit never comes with an error
	a_hit_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (error_code == ERR_NONE))
		else $error("hit reported together with an error");

endmodule

`default_nettype wire

/* rtl/umpq_datapath.sv */
// key store, count, scan pipeline and result registers
`timescale 1ns / 1ps
`default_nettype none

module umpq_datapath
	import umpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire umpq_cmd_t               cmd,
	output umpq_sts_t                    sts,
	input  wire logic [OP_W-1:0]         in_op,
	input  wire logic signed [KEY_W-1:0] in_key,
	output logic signed [KEY_W-1:0]      min_key,
	output logic                         hit,
	output logic [ERR_W-1:0]             error_code,
	output logic [OCC_W-1:0]             occupancy
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [KEY_W-1:0] mem [CAPACITY];

	logic [OP_W-1:0]         op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           scan_idx_q;
	logic [CW-1:0]           j_q;
	logic signed [KEY_W-1:0] best_key_q;
	logic [AW-1:0]           best_idx_q;
	logic                    found_q;
	logic [ERR_W-1:0]        err_q;
	logic                    rdv_s1;
	logic [AW-1:0]           rd_idx_s1;
	logic signed [KEY_W-1:0] rd_data_q;

	logic [CW-1:0]           count_m1;
	logic                    is_min, is_del, is_has, is_ins;
	logic                    full, empty, match, scan_wr, ins_ok;
	logic                    we, re;
	logic [AW-1:0]           waddr, raddr;
	logic signed [KEY_W-1:0] wdata;

	assign count_m1 = count_q - CW'(1);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign is_ins   = (op_q == OP_INSERT);
	assign is_min   = (op_q == OP_REMOVE) || (op_q == OP_PEEK);
	assign is_del   = (op_q == OP_DELETE);
	assign is_has   = (op_q == OP_CONTAINS);
	assign match    = (rd_data_q == key_q);
	assign scan_wr  = rdv_s1 && is_del && !match;
	assign ins_ok   = cmd.decide && is_ins && !full;

	assign sts.op        = op_q;
	assign sts.empty     = empty;
	assign sts.scan_last = (CW'(scan_idx_q) == count_m1);

	// write port: insert, compaction during delete, or move of last entry
	always_comb begin
		we    = 1'b0;
		waddr = scan_idx_q;
		wdata = rd_data_q;
		if (ins_ok) begin
			we    = 1'b1;
			waddr = count_q[AW-1:0];
			wdata = key_q;
		end else if (cmd.move_wr) begin
			we    = 1'b1;
			waddr = best_idx_q;
		end else if (scan_wr) begin
			we    = 1'b1;
			waddr = j_q[AW-1:0];
		end
	end

	assign re    = cmd.issue || cmd.move_rd;
	assign raddr = cmd.move_rd ? count_m1[AW-1:0] : scan_idx_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			rdv_s1 <= cmd.issue;
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.decide && op_q == OP_CLEAR) begin
				count_q <= '0;
			end else if (cmd.commit && is_del) begin
				count_q <= j_q;
			end else if (cmd.move_wr) begin
				count_q <= count_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (cmd.load) begin
			op_q       <= in_op;
			key_q      <= in_key;
			scan_idx_q <= '0;
			j_q        <= '0;
			found_q    <= 1'b0;
			err_q      <= ERR_NONE;
		end
		if (cmd.decide) begin
			if (is_ins && full) begin
				err_q <= ERR_FULL;
			end else if (is_min && empty) begin
				err_q <= ERR_EMPTY;
			end
			if (ins_ok) begin
				found_q <= 1'b1;
			end
		end
		if (cmd.issue) begin
			scan_idx_q <= scan_idx_q + AW'(1);
		end
		if (rdv_s1) begin
			if (is_min && (rd_idx_s1 == '0 || rd_data_q < best_key_q)) begin
				best_key_q <= rd_data_q;
				best_idx_q <= rd_idx_s1;
			end
			if ((is_del || is_has) && match) begin
				found_q <= 1'b1;
			end
			if (scan_wr) begin
				j_q <= j_q + CW'(1);
			end
		end
		if (cmd.out_load) begin
			min_key    <= (is_min && err_q == ERR_NONE) ? best_key_q : '0;
			hit        <= found_q;
			error_code <= err_q;
			occupancy  <= OCC_W'(count_q);
		end
	end

endmodule

`default_nettype wire

/* rtl/umpq_ctrl.sv */
// sequencing state machine and handshake control
`timescale 1ns / 1ps
`default_nettype none

module umpq_ctrl
	import umpq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire umpq_sts_t sts,
	output umpq_cmd_t      cmd
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_DECIDE  = 8'b0000_0010,
		ST_SCAN    = 8'b0000_0100,
		ST_DRAIN   = 8'b0000_1000,
		ST_FIN     = 8'b0001_0000,
		ST_MOVE_RD = 8'b0010_0000,
		ST_MOVE_WR = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				case (sts.op)
					OP_REMOVE, OP_PEEK, OP_DELETE, OP_CONTAINS: begin
						state_d = sts.empty ? ST_RESP : ST_SCAN;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.commit = 1'b1;
				state_d    = (sts.op == OP_REMOVE) ? ST_MOVE_RD : ST_RESP;
			end
			ST_MOVE_RD: begin
				cmd.move_rd = 1'b1;
				state_d     = ST_MOVE_WR;
			end
			ST_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sim/tb.sv */
// testbench for the unordered min-priority queue: random and directed requests, checked against a shadow queue
`timescale 1ns / 1ps

module tb;
	import umpq_pkg::*;

	// op code 7 is left unused by the block and must act as a no-op
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	localparam int KEY_SLOTS      = CAPACITY_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 80;

	typedef struct {
		logic [OP_W-1:0]         req_op;
		logic signed [KEY_W-1:0] req_key;
	} request_t;

	typedef struct {
		logic signed [KEY_W-1:0] min_key;
		logic                    hit;
		logic [ERR_W-1:0]        error_code;
		logic [OCC_W-1:0]        occupancy;
	} reply_t;

	// ports, the driven ones all known from time zero
	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [OP_W-1:0]         op         = '0;
	logic signed [KEY_W-1:0] key        = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic signed [KEY_W-1:0] min_key;
	logic                    hit;
	logic [ERR_W-1:0]        error_code;
	logic [OCC_W-1:0]        occupancy;

	// requests waiting to be driven, replies waiting to be seen
	request_t request_backlog[$];
	reply_t   reply_fifo[$];

	// shadow copy of the queue contents
	logic signed [KEY_W-1:0] held_keys [KEY_SLOTS];
	int                      held_count = 0;

	int send_idle_pct = 15;
	int recv_idle_pct = 71;
	int mismatch_count = 0;
	int requests_queued = 0;
	int quiet_cycles = 0;

	unordered_min_priority_queue_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.min_key    (min_key),
		.hit        (hit),
		.error_code (error_code),
		.occupancy  (occupancy)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// apply one request to the shadow queue and return the reply it should produce
	function automatic reply_t apply_request(logic [OP_W-1:0] req_op,
		logic signed [KEY_W-1:0] req_key);
		reply_t r;
		int best;
		int kept;
		r = '{default: '0};
		case (req_op)
			OP_INSERT: begin
				if (held_count >= KEY_SLOTS) begin
					r.error_code = ERR_FULL;
				end else begin
					held_keys[held_count] = req_key;
					held_count++;
					r.hit = 1'b1;
				end
			end
			OP_REMOVE, OP_PEEK: begin
				if (held_count == 0) begin
					r.error_code = ERR_EMPTY;
				end else begin
					best = 0;
					for (int i = 1; i < held_count; i++)
						if (held_keys[i] < held_keys[best])
							best = i;
					r.min_key = held_keys[best];
					// removal backfills the hole with the last key, order is invisible anyway
					if (req_op == OP_REMOVE) begin
						held_keys[best] = held_keys[held_count - 1];
						held_count--;
					end
				end
			end
			OP_DELETE: begin
				kept = 0;
				for (int i = 0; i < held_count; i++) begin
					if (held_keys[i] != req_key) begin
						held_keys[kept] = held_keys[i];
						kept++;
					end
				end
				r.hit = (kept != held_count);
				held_count = kept;
			end
			OP_CONTAINS: begin
				for (int i = 0; i < held_count; i++)
					if (held_keys[i] == req_key)
						r.hit = 1'b1;
			end
			OP_CLEAR: begin
				held_count = 0;
			end
			default: begin
			end
		endcase
		r.occupancy = held_count[OCC_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// request side: present one beat at a time, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		request_t next_req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// beat taken at this edge: predict its reply now
			if (in_valid && in_ready)
				reply_fifo.push_back(apply_request(op, key));
			if (!in_valid || in_ready) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = request_backlog.pop_front();
					in_valid <= 1'b1;
					op <= next_req.req_op;
					key <= next_req.req_key;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result side: random backpressure, compare every beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_fifo.size() == 0) begin
					flag_mismatch("result beat with no request outstanding");
				end else begin
					want = reply_fifo.pop_front();
					if (min_key !== want.min_key)
						flag_mismatch($sformatf("min_key %0d, expected %0d",
							min_key, want.min_key));
					if (hit !== want.hit)
						flag_mismatch($sformatf("hit %b, expected %b", hit, want.hit));
					if (error_code !== want.error_code)
						flag_mismatch($sformatf("error_code %0d, expected %0d",
							error_code, want.error_code));
					if (occupancy !== want.occupancy)
						flag_mismatch($sformatf("occupancy %0d, expected %0d",
							occupancy, want.occupancy));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: too long with no beat on either channel means the block hung
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic queue_request(logic [OP_W-1:0] req_op, logic signed [KEY_W-1:0] req_key);
		request_t r;
		r.req_op = req_op;
		r.req_key = req_key;
		request_backlog.push_back(r);
		requests_queued++;
	endtask

	// mostly a small pool so duplicates and membership hits are common
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return $urandom_range(15) - 8;
			6, 7:             return $urandom();
			8: begin
				case ($urandom_range(3))
					0:       return 32'h8000_0000;
					1:       return 32'h7fff_ffff;
					2:       return '0;
					default: return '1;
				endcase
			end
			default: return 32'h8000_0000 + $urandom_range(3);
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35) return OP_INSERT;
		if (roll < 50) return OP_REMOVE;
		if (roll < 60) return OP_PEEK;
		if (roll < 70) return OP_DELETE;
		if (roll < 85) return OP_CONTAINS;
		if (roll < 92) return OP_SIZE;
		if (roll < 96) return OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// one well-formed burst with random content
	task automatic queue_burst();
		int n;
		logic signed [KEY_W-1:0] k;
		case ($urandom_range(9))
			0, 1, 2: begin
				// fill, long enough at times to hit the full refusal
				n = $urandom_range(1, 70);
				repeat (n) begin
					queue_request(OP_INSERT, pick_key());
					if ($urandom_range(7) == 0)
						queue_request($urandom_range(1) ? OP_PEEK : OP_CONTAINS, pick_key());
				end
			end
			3, 4: begin
				// drain, often past empty
				n = $urandom_range(1, 70);
				repeat (n) begin
					queue_request(OP_REMOVE, pick_key());
					if ($urandom_range(7) == 0)
						queue_request(OP_PEEK, pick_key());
				end
			end
			5, 6, 7: begin
				n = $urandom_range(10, 30);
				repeat (n) queue_request(pick_op(), pick_key());
			end
			8: begin
				// duplicates, then delete every copy
				k = pick_key();
				n = $urandom_range(1, 4);
				repeat (n) queue_request(OP_INSERT, k);
				queue_request(OP_CONTAINS, k);
				queue_request(OP_DELETE, k);
				queue_request(OP_CONTAINS, k);
				queue_request(OP_DELETE, k);
			end
			default: begin
				queue_request(OP_CLEAR, pick_key());
				queue_request(OP_REMOVE, pick_key());
				queue_request(OP_PEEK, pick_key());
				queue_request(OP_SIZE, pick_key());
			end
		endcase
	endtask

	// hold off until every request has been sent and answered
	task automatic wait_all_replied();
		while (request_backlog.size() != 0 || in_valid || reply_fifo.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		// requests on the empty queue
		queue_request(OP_REMOVE, 32'sd0);
		queue_request(OP_PEEK, 32'sd0);
		queue_request(OP_DELETE, 32'sd5);
		queue_request(OP_CONTAINS, 32'sd0);
		queue_request(OP_SIZE, 32'sd0);
		queue_request(OP_UNUSED, 32'hffff_ffff);
		// extremes and a duplicate
		queue_request(OP_INSERT, 32'h7fff_ffff);
		queue_request(OP_INSERT, 32'h8000_0000);
		queue_request(OP_INSERT, 32'sd0);
		queue_request(OP_INSERT, -32'sd1);
		queue_request(OP_INSERT, -32'sd1);
		queue_request(OP_INSERT, 32'sd1);
		queue_request(OP_PEEK, 32'sd0);
		queue_request(OP_CONTAINS, 32'h7fff_ffff);
		queue_request(OP_CONTAINS, 32'sd2);
		// delete both copies, then delete of an absent key
		queue_request(OP_DELETE, -32'sd1);
		queue_request(OP_DELETE, -32'sd1);
		queue_request(OP_REMOVE, 32'sd0);
		queue_request(OP_REMOVE, 32'sd0);
		queue_request(OP_UNUSED, 32'h5a5a_a5a5);
		queue_request(OP_SIZE, 32'sd0);
		queue_request(OP_CLEAR, 32'sd0);
		queue_request(OP_PEEK, 32'sd0);
		// fill to capacity, one refused insert, then scans over a full store
		repeat (KEY_SLOTS) queue_request(OP_INSERT, pick_key());
		queue_request(OP_INSERT, 32'sd7);
		queue_request(OP_PEEK, 32'sd0);
		queue_request(OP_CONTAINS, pick_key());
		queue_request(OP_REMOVE, 32'sd0);
		queue_request(OP_INSERT, 32'h8000_0000);
		queue_request(OP_INSERT, 32'sd7);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// phase 1: slow receiver
		while (requests_queued < 633) queue_burst();
		wait_all_replied();

		// phase 2: slow sender
		send_idle_pct = 71;
		recv_idle_pct = 15;
		while (requests_queued < 1266) queue_burst();
		wait_all_replied();

		// phase 3: back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (requests_queued < 1900) queue_burst();
		wait_all_replied();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/umpq_pkg.sv
rtl/umpq_datapath.sv
rtl/umpq_ctrl.sv
rtl/unordered_min_priority_queue_top.sv
sim/tb.sv
